@@ rtl/core/moving_average_crossover_signal_defines.svh @@
// ----------------------------------------------------------------------------
// moving average crossover signal: assertion macros
// clocked, reset-qualified concurrent assertion helpers
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH

// generic form with explicit clock and active-low reset
`define MAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// shorthand for the block's own clock and reset names
`define MAC_ASSERT_CLK(lbl, prop, msg) \
  `MAC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/mac_pkg.sv @@
// ----------------------------------------------------------------------------
// mac_pkg
// shared widths, codes, types and saturating helpers
// ----------------------------------------------------------------------------
package mac_pkg;

  localparam int unsigned PRICE_W   = 24;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_OFFSET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_OFFSET = CFG_IDX_W'(1);

  localparam logic [OFFSET_W-1:0] STOP_OFFSET_RST  = OFFSET_W'(200);
  localparam logic [OFFSET_W-1:0] LIMIT_OFFSET_RST = OFFSET_W'(50);

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  typedef enum logic [1:0] {
    SIG_NONE  = 2'd0,
    SIG_LONG  = 2'd1,
    SIG_SHORT = 2'd2
  } sig_e;

  typedef struct packed {
    sig_e               sig;
    logic [PRICE_W-1:0] stop;
    logic [PRICE_W-1:0] limit;
    logic [PRICE_W-1:0] avg;
  } result_t;

  // price plus offset, clamped at full scale
  function automatic logic [PRICE_W-1:0] sat_add(input logic [PRICE_W-1:0] a,
                                                 input logic [OFFSET_W-1:0] b);
    logic [PRICE_W:0] s;
    s = {1'b0, a} + {{(PRICE_W + 1 - OFFSET_W){1'b0}}, b};
    return s[PRICE_W] ? PRICE_MAX : s[PRICE_W-1:0];
  endfunction

  // price minus offset, clamped at zero
  function automatic logic [PRICE_W-1:0] sat_sub(input logic [PRICE_W-1:0] a,
                                                 input logic [OFFSET_W-1:0] b);
    logic [PRICE_W-1:0] bx;
    bx = {{(PRICE_W - OFFSET_W){1'b0}}, b};
    return (a > bx) ? (a - bx) : '0;
  endfunction

endpackage

@@ rtl/core/mac_price_if.sv @@
// ----------------------------------------------------------------------------
// mac_price_if
// valid/ready channel carrying one price sample per transaction
// ----------------------------------------------------------------------------
interface mac_price_if;
  import mac_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

@@ rtl/core/mac_result_if.sv @@
// ----------------------------------------------------------------------------
// mac_result_if
// valid/ready channel carrying one crossover result per transaction
// ----------------------------------------------------------------------------
interface mac_result_if;
  import mac_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         signal;
  logic [PRICE_W-1:0] stop_price;
  logic [PRICE_W-1:0] limit_price;
  logic [PRICE_W-1:0] average_price;

  modport source (output valid, output signal, output stop_price,
                  output limit_price, output average_price, input ready);
  modport sink   (input valid, input signal, input stop_price,
                  input limit_price, input average_price, output ready);
endinterface

@@ rtl/core/mac_cell.sv @@
// ----------------------------------------------------------------------------
// mac_cell
// one window slot: holds a sample and passes it on at each shift
// ----------------------------------------------------------------------------
module mac_cell (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [mac_pkg::PRICE_W-1:0] sample_i,
  output logic [mac_pkg::PRICE_W-1:0] sample_o
);
  import mac_pkg::*;

  logic [PRICE_W-1:0] sample_q;

  // payload only, no reset: slots are meaningless until written
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

@@ rtl/core/mac_chain.sv @@
// ----------------------------------------------------------------------------
// mac_chain
// row of window cells; newest sample at the head, oldest at the tail
// ----------------------------------------------------------------------------
module mac_chain #(
  parameter int unsigned WINDOW_LEN = 32
) (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  logic [mac_pkg::PRICE_W-1:0] price_i,
  output logic [mac_pkg::PRICE_W-1:0] newest_o,
  output logic [mac_pkg::PRICE_W-1:0] oldest_o
);
  import mac_pkg::*;

  logic [PRICE_W-1:0] tap [WINDOW_LEN];

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      mac_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift_i),
        .sample_i (price_i),
        .sample_o (tap[k])
      );
    end else begin : g_body
      mac_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (shift_i),
        .sample_i (tap[k-1]),
        .sample_o (tap[k])
      );
    end
  end

  assign newest_o = tap[0];
  assign oldest_o = tap[WINDOW_LEN-1];

endmodule

@@ rtl/core/mac_track.sv @@
// ----------------------------------------------------------------------------
// mac_track
// running sum, warm-up count, last trade price and crossover decision
// ----------------------------------------------------------------------------
module mac_track #(
  parameter int unsigned WINDOW_LEN = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [mac_pkg::PRICE_W-1:0]  price_i,
  input  logic [mac_pkg::PRICE_W-1:0]  newest_i,
  input  logic [mac_pkg::PRICE_W-1:0]  oldest_i,
  input  logic [mac_pkg::OFFSET_W-1:0] stop_off_i,
  input  logic [mac_pkg::OFFSET_W-1:0] limit_off_i,
  output mac_pkg::result_t             result_o
);
  import mac_pkg::*;

  localparam int unsigned LOG2_W = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = PRICE_W + LOG2_W;
  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(WINDOW_LEN + 1);

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PRICE_W-1:0] last_q, last_d;
  logic               full;
  logic [PRICE_W-1:0] drop;
  logic [PRICE_W-1:0] avg;
  logic               armed, go_long, go_short;

  // tail slot holds real data only once the window has wrapped
  assign full = (count_q >= CNT_FULL);
  assign drop = full ? oldest_i : '0;

  assign sum_d = sum_q - {{LOG2_W{1'b0}}, drop} + {{LOG2_W{1'b0}}, price_i};
  assign avg   = sum_d[SUM_W-1 -: PRICE_W];

  assign count_d = (count_q == CNT_SAT) ? count_q : count_q + CNT_W'(1);

  assign armed    = full && (avg != '0) && (price_i != last_q);
  assign go_long  = armed && (newest_i < avg) && (price_i >= avg);
  assign go_short = armed && (newest_i > avg) && (price_i <= avg);

  always_comb begin
    result_o     = '0;
    result_o.sig = SIG_NONE;
    result_o.avg = avg;
    last_d       = last_q;
    if (go_long) begin
      result_o.sig   = SIG_LONG;
      result_o.stop  = sat_sub(price_i, stop_off_i);
      result_o.limit = sat_add(price_i, limit_off_i);
      last_d         = price_i;
    end else if (go_short) begin
      result_o.sig   = SIG_SHORT;
      result_o.stop  = sat_add(price_i, stop_off_i);
      result_o.limit = sat_sub(price_i, limit_off_i);
      last_d         = price_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      last_q  <= '0;
    end else if (accept_i) begin
      sum_q   <= sum_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

endmodule

@@ rtl/core/moving_average_crossover_signal.sv @@
// a result appears in the cycle after its price sample is accepted
// throughput: one sample per cycle unless a result waits; the running-sum update (subtract tail
//   cell, add new sample, shift) and the crossover compares take effect as each sample is accepted
// a result left waiting holds off the input; taken, a new sample enters that cycle
// reset: sum, sample count and last trade price clear; offsets return to 200/50
// ----------------------------------------------------------------------------
// moving_average_crossover_signal
// sma crossover trade signal with stop and limit prices over a cell chain
// ----------------------------------------------------------------------------
`include "moving_average_crossover_signal_defines.svh"

module moving_average_crossover_signal #(
  // window length, power of two in 2..256
  parameter int unsigned WINDOW_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mac_pkg::OFFSET_W-1:0]  cfg_data_i,
  mac_price_if.sink                     price_i,
  mac_result_if.source                  result_o
);
  import mac_pkg::*;

  // offsets, to be written by the user only while the block is idle; the block leaves this to the user
  logic [OFFSET_W-1:0] stop_off_q;
  logic [OFFSET_W-1:0] limit_off_q;

  logic               in_acc;
  logic [PRICE_W-1:0] newest, oldest;
  result_t            res_d, res_q;
  logic               out_valid_q;

  // result register status, used by the checks below
  logic               out_held;
  logic               out_trade;
  logic               out_idle;

  // output register parts the channels: accept whenever the slot frees up
  assign price_i.ready = !out_valid_q || result_o.ready;
  assign in_acc        = price_i.valid && price_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_off_q  <= STOP_OFFSET_RST;
      limit_off_q <= LIMIT_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STOP_OFFSET:  stop_off_q  <= cfg_data_i;
        REG_LIMIT_OFFSET: limit_off_q <= cfg_data_i;
        default: ;  // index beyond the register list: dropped
      endcase
    end
  end

  // window: each accepted sample shifts one cell toward the tail
  mac_chain #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_chain (
    .clk_i    (clk_i),
    .shift_i  (in_acc),
    .price_i  (price_i.price),
    .newest_o (newest),
    .oldest_o (oldest)
  );

  // decision uses the head cell before the shift as the previous sample
  mac_track #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .price_i     (price_i.price),
    .newest_i    (newest),
    .oldest_i    (oldest),
    .stop_off_i  (stop_off_q),
    .limit_off_i (limit_off_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.signal        = res_q.sig;
  assign result_o.stop_price    = res_q.stop;
  assign result_o.limit_price   = res_q.limit;
  assign result_o.average_price = res_q.avg;

  assign out_held  = out_valid_q && !result_o.ready;
  assign out_trade = out_valid_q && (res_q.sig != SIG_NONE);
  assign out_idle  = out_valid_q && (res_q.sig == SIG_NONE);

  // input is held off only by a waiting, untaken result
  `MAC_ASSERT_CLK(a_backpressure_src, !price_i.ready |-> out_held, "stall without pending result")

  // every accepted sample leaves a result in the output register
  `MAC_ASSERT_CLK(a_result_follows, in_acc |=> out_valid_q, "accepted sample produced no result")

  // a trade is never given against a zero average
  `MAC_ASSERT_CLK(a_trade_avg_nonzero, out_trade |-> (res_q.avg != '0), "trade with zero average")

  // no-trade results carry zero stop and limit prices
  `MAC_ASSERT_CLK(a_idle_prices_zero, out_idle |-> ({res_q.stop, res_q.limit} == '0), "idle prices")

endmodule
